// ===== rtl/core/ic_pkg.sv =====
// ----------------------------------------------------------------------------
// ic_pkg: shared types and constants for the inversion counter
// Token control bits that travel down the cell row, field widths and the
// saturation limit of the running total.
// ----------------------------------------------------------------------------
package ic_pkg;

    // Width of one sequence element
    localparam int VALUE_W = 32;

    // Width of the reported total and its saturation value
    localparam int TOTAL_W = 15;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Control bits of a token moving along the row
    typedef struct packed {
        logic valid;
        logic last;
    } ic_ctl_t;

endpackage

// ===== rtl/core/ic_cell.sv =====
// ----------------------------------------------------------------------------
// ic_cell: one storage cell of the inversion counter row
// Holds the value of one sequence position. A passing token from a later
// position is compared against it and bumps its count when the stored value
// is greater; the token whose position matches writes its value here.
// ----------------------------------------------------------------------------
module ic_cell #(
    parameter int IDX_W    = 9,
    parameter int CELL_IDX = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  ic_pkg::ic_ctl_t                   ctl_in,
    input  logic signed [ic_pkg::VALUE_W-1:0] value_in,
    input  logic [IDX_W-1:0]                  idx_in,
    input  logic [IDX_W-1:0]                  cnt_in,
    output ic_pkg::ic_ctl_t                   ctl_out,
    output logic signed [ic_pkg::VALUE_W-1:0] value_out,
    output logic [IDX_W-1:0]                  idx_out,
    output logic [IDX_W-1:0]                  cnt_out
);

    localparam logic [IDX_W-1:0] CELL_POS = IDX_W'(CELL_IDX);

    logic signed [ic_pkg::VALUE_W-1:0] stored_reg;
    ic_pkg::ic_ctl_t                   ctl_reg;
    logic signed [ic_pkg::VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic [IDX_W-1:0]                  cnt_reg;
    logic [IDX_W-1:0]                  cnt_next;
    logic                              hit;
    logic                              store_here;

    // Earlier element stored here and strictly greater than the token value
    assign hit        = ctl_in.valid && (CELL_POS < idx_in) && (stored_reg > value_in);
    assign store_here = ctl_in.valid && (idx_in == CELL_POS);
    assign cnt_next   = cnt_in + IDX_W'(hit);

    // Token control stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_in;
        end
    end

    // Token payload stage and stored element
    always_ff @(posedge aclk) begin
        if (advance) begin
            value_reg <= value_in;
            idx_reg   <= idx_in;
            cnt_reg   <= cnt_next;
            if (store_here) begin
                stored_reg <= value_in;
            end
        end
    end

    assign ctl_out   = ctl_reg;
    assign value_out = value_reg;
    assign idx_out   = idx_reg;
    assign cnt_out   = cnt_reg;

endmodule

// ===== rtl/core/ic_tail.sv =====
// ----------------------------------------------------------------------------
// ic_tail: total accumulator and result register
// Adds each token's count to a saturating running total, flags tokens that
// found the row full, and presents one result per sequence on the m_ side.
// ----------------------------------------------------------------------------
module ic_tail #(
    parameter int IDX_W = 9,
    parameter int DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ic_pkg::ic_ctl_t               ctl_in,
    input  logic [IDX_W-1:0]              idx_in,
    input  logic [IDX_W-1:0]              cnt_in,
    output logic                          advance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ic_pkg::TOTAL_W-1:0]    m_inversions,
    output logic                          m_overflow
);

    localparam int SUM_W = ic_pkg::TOTAL_W + 1;
    localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(DEPTH);

    logic [ic_pkg::TOTAL_W-1:0] total_reg;
    logic [ic_pkg::TOTAL_W-1:0] total_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [SUM_W-1:0]           sum;
    logic                       m_valid_reg;
    logic [ic_pkg::TOTAL_W-1:0] inv_reg;
    logic                       ovf_out_reg;
    logic                       take;

    // Row halts only when a closing token meets a result still waiting
    assign advance = !(ctl_in.valid && ctl_in.last && m_valid_reg && !m_ready);
    assign take    = advance && ctl_in.valid;

    // Saturating add of this token's count
    assign sum        = SUM_W'(total_reg) + SUM_W'(cnt_in);
    assign total_next = (sum >= SUM_W'(ic_pkg::TOTAL_MAX)) ? ic_pkg::TOTAL_MAX
                                                          : sum[ic_pkg::TOTAL_W-1:0];
    assign ovf_next   = ovf_reg || (idx_in == FULL_IDX);

    // Sequence accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (take) begin
            if (ctl_in.last) begin
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                total_reg <= total_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take && ctl_in.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && ctl_in.last) begin
            inv_reg     <= total_next;
            ovf_out_reg <= ovf_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inversions = inv_reg;
    assign m_overflow   = ovf_out_reg;

    // A closing token always loads a result
    a_last_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ctl_in.last) |=> m_valid_reg)
        else $error("closing token did not produce a result");

    // Accumulator is clear after a closing token
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ctl_in.last) |=> (total_reg == '0 && !ovf_reg))
        else $error("accumulator not cleared after sequence end");

    // Row only stalls on a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |-> (m_valid_reg && !m_ready))
        else $error("row stalled without a waiting result");

endmodule

// ===== rtl/core/inversion_counter.sv =====
// ----------------------------------------------------------------------------
// inversion_counter: streaming inversion count over signed sequences
// Counts pairs in which an earlier element is strictly greater than a later
// one, using a row of DEPTH cells that each hold one stored element.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one signed element per transfer (s_value), s_last_item high on
//   the final element of a sequence. m_ channel: one result per sequence,
//   m_inversions (saturates at 32767) and m_overflow (sequence was longer
//   than DEPTH; extra elements are compared but not stored).
//   Throughput: one element per cycle, back to back, within and across
//   sequences, while the row is not stalled. Each element travels the cell
//   row one cell per cycle while it advances, and the result is registered
//   in the tail once the last element's token leaves the final cell.
//   Reset: aresetn clears the token valid bits, the position counter and the
//   accumulator; the stored elements need no clearing because each token
//   only looks at cells written earlier in its own sequence.
//   Stall: while a result waits on m_ready and the next closing token reaches
//   the end of the row, the whole row holds and s_ready drops.
// ----------------------------------------------------------------------------
module inversion_counter #(
    parameter int DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ic_pkg::VALUE_W-1:0] s_value,
    input  logic                              s_last_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ic_pkg::TOTAL_W-1:0]        m_inversions,
    output logic                              m_overflow
);

    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(DEPTH);

    logic                              advance;
    logic [IDX_W-1:0]                  pos_reg;
    logic [IDX_W-1:0]                  pos_next;
    logic                              s_xfer;

    ic_pkg::ic_ctl_t                   chain_ctl   [0:DEPTH];
    logic signed [ic_pkg::VALUE_W-1:0] chain_value [0:DEPTH];
    logic [IDX_W-1:0]                  chain_idx   [0:DEPTH];
    logic [IDX_W-1:0]                  chain_cnt   [0:DEPTH];

    assign s_ready = advance;
    assign s_xfer  = s_valid && s_ready;

    // Sequence position of the next element, held at DEPTH once full
    assign pos_next = (pos_reg == FULL_IDX) ? pos_reg : pos_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (s_xfer) begin
            pos_reg <= s_last_item ? '0 : pos_next;
        end
    end

    // Token entering the row
    assign chain_ctl[0].valid = s_valid;
    assign chain_ctl[0].last  = s_last_item;
    assign chain_value[0]     = s_value;
    assign chain_idx[0]       = pos_reg;
    assign chain_cnt[0]       = '0;

    // Cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ic_cell #(
            .IDX_W   (IDX_W),
            .CELL_IDX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .ctl_in   (chain_ctl[i]),
            .value_in (chain_value[i]),
            .idx_in   (chain_idx[i]),
            .cnt_in   (chain_cnt[i]),
            .ctl_out  (chain_ctl[i+1]),
            .value_out(chain_value[i+1]),
            .idx_out  (chain_idx[i+1]),
            .cnt_out  (chain_cnt[i+1])
        );
    end

    // Accumulator and result register
    ic_tail #(
        .IDX_W(IDX_W),
        .DEPTH(DEPTH)
    ) u_tail (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl_in      (chain_ctl[DEPTH]),
        .idx_in      (chain_idx[DEPTH]),
        .cnt_in      (chain_cnt[DEPTH]),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_inversions(m_inversions),
        .m_overflow  (m_overflow)
    );

    // Position never passes the row length
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= FULL_IDX)
        else $error("position counter beyond row length");

    // A closing transfer restarts the position count
    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_last_item) |=> (pos_reg == '0))
        else $error("position counter not restarted after sequence end");

    // Position advances by one on an ordinary transfer while not full
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !s_last_item && pos_reg != FULL_IDX) |=>
        (pos_reg == $past(pos_reg) + IDX_W'(1)))
        else $error("position counter did not advance");

endmodule
